@@ rtl/core/ttio_pkg.sv @@
// ----------------------------------------------------------------------------
// ttio_pkg
// Shared types and codes for the teletype I/O interface: operation codes,
// function code groups, timer request codes and the activity state.
// ----------------------------------------------------------------------------
package ttio_pkg;

  // Operation codes carried by the input item.
  localparam logic [3:0] OP_INA         = 4'd0;
  localparam logic [3:0] OP_OCP         = 4'd1;
  localparam logic [3:0] OP_SKS         = 4'd2;
  localparam logic [3:0] OP_OTA         = 4'd3;
  localparam logic [3:0] OP_SMK         = 4'd4;
  localparam logic [3:0] OP_DUMMY_DONE  = 4'd5;
  localparam logic [3:0] OP_OUTPUT_DONE = 4'd6;
  localparam logic [3:0] OP_INPUT_DONE  = 4'd7;
  localparam logic [3:0] OP_CLEAR       = 4'd8;

  // Full function codes recognized by the input instruction.
  localparam logic [8:0] FC_INA_WORD = 9'o004;
  localparam logic [8:0] FC_INA_SIX  = 9'o204;

  // Function code groups, taken from the top three bits of the code.
  localparam logic [2:0] FG_0 = 3'o0;
  localparam logic [2:0] FG_1 = 3'o1;
  localparam logic [2:0] FG_2 = 3'o2;
  localparam logic [2:0] FG_4 = 3'o4;
  localparam logic [2:0] FG_5 = 3'o5;

  // Timer start requests.
  localparam logic [1:0] TMR_NONE   = 2'd0;
  localparam logic [1:0] TMR_INPUT  = 2'd1;
  localparam logic [1:0] TMR_OUTPUT = 2'd2;
  localparam logic [1:0] TMR_DUMMY  = 2'd3;

  // Character that stops the reader, compared on seven bits.
  localparam logic [6:0] STOP_CHAR = 7'o023;

  // Bit of the mask word that enables this device's interrupt.
  localparam int unsigned MASK_BIT_POS = 5;

  // What the interface is currently timing.
  typedef enum logic [3:0] {
    ACT_NONE   = 4'b0001,
    ACT_INPUT  = 4'b0010,
    ACT_OUTPUT = 4'b0100,
    ACT_DUMMY  = 4'b1000
  } activity_t;

endpackage

@@ rtl/core/teletype_io_interface.sv @@
// ----------------------------------------------------------------------------
// teletype_io_interface
// Teletype I/O interface: executes I/O instructions and completion events
// against the data buffer, flags, activity state, mask bit and interrupt line.
// ----------------------------------------------------------------------------
// The block takes one item (an instruction or a timer completion event) in
// every clock cycle while the out_ channel does not stall and returns exactly
// one result item for each. An item is held in an input register, then the
// device state and the result register are updated together, so a result
// reaches the out_ channel through the input and result registers. The rate
// is set by the single state-update stage: each item reads the state that the
// item before it left, which the stage has written by the next edge. A stall
// on the out_ channel holds the result register and then the input register.
// ----------------------------------------------------------------------------
module teletype_io_interface (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_operation,
  input  logic [8:0]  in_function_code,
  input  logic [15:0] in_data_in,
  input  logic        in_char_valid,
  input  logic [7:0]  in_char_in,
  input  logic [15:0] in_mask_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status_flag,
  output logic [15:0] out_data_out,
  output logic        out_irq_level,
  output logic [1:0]  out_start_timer,
  output logic        out_print_valid,
  output logic [7:0]  out_print_char,
  output logic        out_bad_function
);

  // Input register.
  logic        in_valid_r;
  logic [3:0]  op_r;
  logic [8:0]  fc_r;
  logic [15:0] din_r;
  logic        cvalid_r;
  logic [7:0]  cin_r;
  logic [15:0] mword_r;

  // Device state.
  logic [15:0]          buffer_r, buffer_nxt;
  logic                 ready_r, ready_nxt;
  logic                 in_wait_r, in_wait_nxt;
  logic                 omode_r, omode_nxt;
  logic                 out_wait_r, out_wait_nxt;
  ttio_pkg::activity_t  act_r, act_nxt;
  logic                 mask_r, mask_nxt;
  logic                 irq_r, irq_nxt;

  // Result register.
  logic        out_valid_r;
  logic        status_r, status_nxt;
  logic [15:0] dout_r, dout_nxt;
  logic [1:0]  timer_r, timer_nxt;
  logic        pvalid_r, pvalid_nxt;
  logic [7:0]  pchar_r, pchar_nxt;
  logic        bad_r, bad_nxt;

  logic        advance;
  logic [2:0]  fgrp;
  logic [15:0] ota_word;

  // The state stage moves when the result register is free or being emptied.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  assign fgrp = fc_r[8:6];

  // Output word with bit 6 replaced by the inverse of bit 5 and the upper byte cleared.
  assign ota_word = {8'h00, din_r[7], ~din_r[5], din_r[5:0]};

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_operation;
      fc_r     <= in_function_code;
      din_r    <= in_data_in;
      cvalid_r <= in_char_valid;
      cin_r    <= in_char_in;
      mword_r  <= in_mask_word;
    end
  end

  // Instruction and event execution.
  always_comb begin
    buffer_nxt   = buffer_r;
    ready_nxt    = ready_r;
    in_wait_nxt  = in_wait_r;
    omode_nxt    = omode_r;
    out_wait_nxt = out_wait_r;
    act_nxt      = act_r;
    mask_nxt     = mask_r;
    irq_nxt      = irq_r;
    status_nxt   = 1'b0;
    dout_nxt     = '0;
    timer_nxt    = ttio_pkg::TMR_NONE;
    pvalid_nxt   = 1'b0;
    pchar_nxt    = '0;
    bad_nxt      = 1'b0;

    unique case (op_r)
      ttio_pkg::OP_INA: begin
        status_nxt = ready_r;
        if (ready_r) begin
          if (fc_r == ttio_pkg::FC_INA_WORD) begin
            dout_nxt = buffer_r;
          end else if (fc_r == ttio_pkg::FC_INA_SIX) begin
            dout_nxt = {10'd0, buffer_r[5:0]};
          end else begin
            bad_nxt = 1'b1;
          end
          in_wait_nxt = 1'b0;
          ready_nxt   = 1'b0;
          irq_nxt     = 1'b0;
        end else if (!in_wait_r && cvalid_r) begin
          buffer_nxt  = {8'h00, cin_r};
          act_nxt     = ttio_pkg::ACT_INPUT;
          in_wait_nxt = 1'b1;
          timer_nxt   = ttio_pkg::TMR_INPUT;
        end
      end
      ttio_pkg::OP_OCP: begin
        if (fgrp == ttio_pkg::FG_0) begin
          omode_nxt = 1'b0;
          act_nxt   = ttio_pkg::ACT_NONE;
          ready_nxt = 1'b0;
          irq_nxt   = 1'b0;
        end else if (fgrp == ttio_pkg::FG_1) begin
          omode_nxt = 1'b1;
          act_nxt   = ttio_pkg::ACT_DUMMY;
          ready_nxt = 1'b1;
          irq_nxt   = irq_r | mask_r;
          timer_nxt = ttio_pkg::TMR_DUMMY;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      ttio_pkg::OP_SKS: begin
        unique case (fgrp)
          ttio_pkg::FG_0: status_nxt = ready_r;
          ttio_pkg::FG_1: status_nxt = (act_r == ttio_pkg::ACT_NONE);
          ttio_pkg::FG_4: status_nxt = !(ready_r && mask_r);
          ttio_pkg::FG_5: status_nxt = !omode_r && ready_r &&
                                       (buffer_r[6:0] == ttio_pkg::STOP_CHAR);
          default:        bad_nxt    = 1'b1;
        endcase
      end
      ttio_pkg::OP_OTA: begin
        status_nxt = ready_r;
        if (ready_r) begin
          if (fgrp == ttio_pkg::FG_0) begin
            buffer_nxt = din_r;
          end else if (fgrp == ttio_pkg::FG_2) begin
            buffer_nxt = ota_word;
          end else begin
            bad_nxt = 1'b1;
          end
          ready_nxt = 1'b0;
          irq_nxt   = 1'b0;
          if (act_r == ttio_pkg::ACT_DUMMY) begin
            out_wait_nxt = 1'b1;
          end else begin
            act_nxt   = ttio_pkg::ACT_OUTPUT;
            timer_nxt = ttio_pkg::TMR_OUTPUT;
          end
        end
      end
      ttio_pkg::OP_SMK: begin
        mask_nxt = mword_r[ttio_pkg::MASK_BIT_POS];
        irq_nxt  = ready_r && mword_r[ttio_pkg::MASK_BIT_POS];
      end
      ttio_pkg::OP_DUMMY_DONE: begin
        if (act_r == ttio_pkg::ACT_DUMMY) begin
          if (out_wait_r) begin
            act_nxt      = ttio_pkg::ACT_OUTPUT;
            timer_nxt    = ttio_pkg::TMR_OUTPUT;
            out_wait_nxt = 1'b0;
          end else begin
            act_nxt = ttio_pkg::ACT_NONE;
          end
        end
      end
      ttio_pkg::OP_OUTPUT_DONE: begin
        if (act_r == ttio_pkg::ACT_OUTPUT) begin
          act_nxt    = ttio_pkg::ACT_NONE;
          ready_nxt  = 1'b1;
          irq_nxt    = irq_r | mask_r;
          pvalid_nxt = 1'b1;
          pchar_nxt  = buffer_r[7:0];
        end
      end
      ttio_pkg::OP_INPUT_DONE: begin
        if (act_r == ttio_pkg::ACT_INPUT) begin
          act_nxt     = ttio_pkg::ACT_NONE;
          in_wait_nxt = 1'b0;
          ready_nxt   = 1'b1;
          irq_nxt     = irq_r | mask_r;
        end
      end
      ttio_pkg::OP_CLEAR: begin
        buffer_nxt   = '0;
        ready_nxt    = 1'b0;
        in_wait_nxt  = 1'b0;
        omode_nxt    = 1'b0;
        out_wait_nxt = 1'b0;
        act_nxt      = ttio_pkg::ACT_NONE;
        mask_nxt     = 1'b0;
        irq_nxt      = 1'b0;
      end
      default: begin
        bad_nxt = 1'b1;
      end
    endcase
  end

  // State and result valid update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_r    <= '0;
      ready_r     <= 1'b0;
      in_wait_r   <= 1'b0;
      omode_r     <= 1'b0;
      out_wait_r  <= 1'b0;
      act_r       <= ttio_pkg::ACT_NONE;
      mask_r      <= 1'b0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        buffer_r   <= buffer_nxt;
        ready_r    <= ready_nxt;
        in_wait_r  <= in_wait_nxt;
        omode_r    <= omode_nxt;
        out_wait_r <= out_wait_nxt;
        act_r      <= act_nxt;
        mask_r     <= mask_nxt;
        irq_r      <= irq_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      status_r <= status_nxt;
      dout_r   <= dout_nxt;
      timer_r  <= timer_nxt;
      pvalid_r <= pvalid_nxt;
      pchar_r  <= pchar_nxt;
      bad_r    <= bad_nxt;
    end
  end

  // The interrupt level shown is the line after this item's step.
  logic irq_out_r;
  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      irq_out_r <= irq_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status_flag  = status_r;
  assign out_data_out     = dout_r;
  assign out_irq_level    = irq_out_r;
  assign out_start_timer  = timer_r;
  assign out_print_valid  = pvalid_r;
  assign out_print_char   = pchar_r;
  assign out_bad_function = bad_r;

endmodule

@@ rtl/core/ttio_checker.sv @@
// ----------------------------------------------------------------------------
// ttio_checker
// Port-level checks on the teletype I/O interface, bound to the top level.
// ----------------------------------------------------------------------------
module ttio_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status_flag,
  input logic [15:0] out_data_out,
  input logic [1:0]  out_start_timer,
  input logic        out_print_valid,
  input logic [7:0]  out_print_char,
  input logic        out_bad_function
);

  // A stalled result keeps its data and print character until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out) &&
      $stable(out_print_char))
    else $error("result item changed while stalled");

  // Nothing is shown the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A printed character comes only from a clean output completion.
  a_print_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_print_valid |->
      out_start_timer == ttio_pkg::TMR_NONE && !out_bad_function &&
      !out_status_flag)
    else $error("print together with another action");

  // The print character is zero unless a character is printed.
  a_print_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_print_valid |-> out_print_char == 8'h00)
    else $error("print character without print");

  // Read data only appears for an input instruction issued while ready.
  a_data_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_out != 16'h0000 |->
      out_status_flag && !out_bad_function)
    else $error("read data without ready");

endmodule

bind teletype_io_interface ttio_checker u_ttio_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status_flag  (out_status_flag),
  .out_data_out     (out_data_out),
  .out_start_timer  (out_start_timer),
  .out_print_valid  (out_print_valid),
  .out_print_char   (out_print_char),
  .out_bad_function (out_bad_function)
);

@@ tb/tb_teletype_io_interface.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_teletype_io_interface
// Self-checking testbench for the teletype I/O interface. A directed run walks
// the input, output and dummy sequences and the error cases, then random
// instruction sequences follow. A behavioral copy of the device predicts the
// result of every accepted item, and the monitor compares each result field by
// field while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_teletype_io_interface;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 90;
  localparam int unsigned MAX_REPORTS  = 10;

  // One instruction or completion event as driven on the in_ channel.
  typedef struct packed {
    logic [3:0]  op;
    logic [8:0]  fc;
    logic [15:0] din;
    logic        cvalid;
    logic [7:0]  cin;
    logic [15:0] mword;
  } tty_instr_t;

  // One result item as seen on the out_ channel.
  typedef struct packed {
    logic        status;
    logic [15:0] data;
    logic        irq;
    logic [1:0]  timer;
    logic        pvalid;
    logic [7:0]  pchar;
    logic        bad;
  } tty_reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status_flag;
  logic [15:0] out_data_out;
  logic        out_irq_level;
  logic [1:0]  out_start_timer;
  logic        out_print_valid;
  logic [7:0]  out_print_char;
  logic        out_bad_function;

  tty_instr_t on_bus = '0;

  teletype_io_interface dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (on_bus.op),
    .in_function_code (on_bus.fc),
    .in_data_in       (on_bus.din),
    .in_char_valid    (on_bus.cvalid),
    .in_char_in       (on_bus.cin),
    .in_mask_word     (on_bus.mword),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status_flag  (out_status_flag),
    .out_data_out     (out_data_out),
    .out_irq_level    (out_irq_level),
    .out_start_timer  (out_start_timer),
    .out_print_valid  (out_print_valid),
    .out_print_char   (out_print_char),
    .out_bad_function (out_bad_function)
  );

  tty_instr_t instr_queue[$];
  tty_reply_t pending_replies[$];
  int unsigned instrs_total;
  int unsigned instrs_accepted = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // Behavioral copy of the device state.
  logic [15:0]         dev_buffer;
  logic                dev_ready;
  logic                dev_in_wait;
  logic                dev_out_mode;
  logic                dev_out_wait;
  ttio_pkg::activity_t dev_activity;
  logic                dev_mask;
  logic                dev_irq;

  // Both sides run without idling while this is set.
  wire calm_window = (instrs_accepted >= 500) && (instrs_accepted < 700);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Returns the device state to its power-up values.
  function automatic void clear_device();
    dev_buffer   = '0;
    dev_ready    = 1'b0;
    dev_in_wait  = 1'b0;
    dev_out_mode = 1'b0;
    dev_out_wait = 1'b0;
    dev_activity = ttio_pkg::ACT_NONE;
    dev_mask     = 1'b0;
    dev_irq      = 1'b0;
  endfunction

  // Executes one instruction or event on the device copy and returns its result.
  function automatic tty_reply_t execute_instr(input tty_instr_t it);
    tty_reply_t r;
    logic [2:0] grp;
    r = '0;
    grp = it.fc[8:6];
    case (it.op)
      ttio_pkg::OP_INA: begin
        r.status = dev_ready;
        if (dev_ready) begin
          if (it.fc == ttio_pkg::FC_INA_WORD) r.data = dev_buffer;
          else if (it.fc == ttio_pkg::FC_INA_SIX) r.data = {10'd0, dev_buffer[5:0]};
          else r.bad = 1'b1;
          dev_in_wait = 1'b0;
          dev_ready   = 1'b0;
          dev_irq     = 1'b0;
        end else if (!dev_in_wait && it.cvalid) begin
          dev_buffer   = {8'd0, it.cin};
          dev_activity = ttio_pkg::ACT_INPUT;
          dev_in_wait  = 1'b1;
          r.timer      = ttio_pkg::TMR_INPUT;
        end
      end
      ttio_pkg::OP_OCP: begin
        if (grp == ttio_pkg::FG_0) begin
          dev_out_mode = 1'b0;
          dev_activity = ttio_pkg::ACT_NONE;
          dev_ready    = 1'b0;
          dev_irq      = 1'b0;
        end else if (grp == ttio_pkg::FG_1) begin
          dev_out_mode = 1'b1;
          dev_activity = ttio_pkg::ACT_DUMMY;
          dev_ready    = 1'b1;
          if (dev_mask) dev_irq = 1'b1;
          r.timer = ttio_pkg::TMR_DUMMY;
        end else begin
          r.bad = 1'b1;
        end
      end
      ttio_pkg::OP_SKS: begin
        case (grp)
          ttio_pkg::FG_0: r.status = dev_ready;
          ttio_pkg::FG_1: r.status = (dev_activity == ttio_pkg::ACT_NONE);
          ttio_pkg::FG_4: r.status = !(dev_ready && dev_mask);
          ttio_pkg::FG_5: r.status = !dev_out_mode && dev_ready &&
                                     (dev_buffer[6:0] == ttio_pkg::STOP_CHAR);
          default: r.bad = 1'b1;
        endcase
      end
      ttio_pkg::OP_OTA: begin
        r.status = dev_ready;
        if (dev_ready) begin
          // The second form swaps in the inverse of bit 5 as bit 6 and clears the upper byte.
          if (grp == ttio_pkg::FG_0)
            dev_buffer = it.din;
          else if (grp == ttio_pkg::FG_2)
            dev_buffer = {8'd0, it.din[7], ~it.din[5], it.din[5:0]};
          else
            r.bad = 1'b1;
          dev_ready = 1'b0;
          dev_irq   = 1'b0;
          if (dev_activity == ttio_pkg::ACT_DUMMY) begin
            dev_out_wait = 1'b1;
          end else begin
            dev_activity = ttio_pkg::ACT_OUTPUT;
            r.timer      = ttio_pkg::TMR_OUTPUT;
          end
        end
      end
      ttio_pkg::OP_SMK: begin
        dev_mask = it.mword[ttio_pkg::MASK_BIT_POS];
        dev_irq  = dev_ready && dev_mask;
      end
      ttio_pkg::OP_DUMMY_DONE: begin
        if (dev_activity == ttio_pkg::ACT_DUMMY) begin
          if (dev_out_wait) begin
            dev_activity = ttio_pkg::ACT_OUTPUT;
            r.timer      = ttio_pkg::TMR_OUTPUT;
            dev_out_wait = 1'b0;
          end else begin
            dev_activity = ttio_pkg::ACT_NONE;
          end
        end
      end
      ttio_pkg::OP_OUTPUT_DONE: begin
        if (dev_activity == ttio_pkg::ACT_OUTPUT) begin
          dev_activity = ttio_pkg::ACT_NONE;
          dev_ready    = 1'b1;
          if (dev_mask) dev_irq = 1'b1;
          r.pvalid = 1'b1;
          r.pchar  = dev_buffer[7:0];
        end
      end
      ttio_pkg::OP_INPUT_DONE: begin
        if (dev_activity == ttio_pkg::ACT_INPUT) begin
          dev_activity = ttio_pkg::ACT_NONE;
          dev_in_wait  = 1'b0;
          dev_ready    = 1'b1;
          if (dev_mask) dev_irq = 1'b1;
        end
      end
      ttio_pkg::OP_CLEAR: clear_device();
      default: r.bad = 1'b1;
    endcase
    r.irq = dev_irq;
    return r;
  endfunction

  // Builds an item of the given operation with every other field random.
  function automatic tty_instr_t rand_instr(input logic [3:0] op);
    tty_instr_t it;
    it.op     = op;
    it.fc     = 9'($urandom_range(0, 511));
    it.din    = 16'($urandom);
    it.cvalid = 1'($urandom_range(0, 1));
    it.cin    = 8'($urandom);
    it.mword  = 16'($urandom);
    return it;
  endfunction

  // Random code in a function group, mostly one of the recognized groups.
  function automatic logic [8:0] group_code(input logic [2:0] g0, input logic [2:0] g1,
                                            input logic [2:0] g2, input logic [2:0] g3);
    logic [2:0] g;
    case ($urandom_range(0, 9))
      0, 1: g = g0;
      2, 3: g = g1;
      4, 5: g = g2;
      6, 7: g = g3;
      default: g = 3'($urandom_range(0, 7));
    endcase
    return {g, 6'($urandom_range(0, 63))};
  endfunction

  // Input instruction code: usually one of the two read forms.
  function automatic logic [8:0] ina_code();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ttio_pkg::FC_INA_WORD;
      4, 5, 6, 7: return ttio_pkg::FC_INA_SIX;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic void add_instr(input logic [3:0] op, input logic [8:0] fc,
                                    input logic [15:0] din, input logic cvalid,
                                    input logic [7:0] cin, input logic [15:0] mword);
    instr_queue.push_back({op, fc, din, cvalid, cin, mword});
  endfunction

  function automatic void add_rand(input logic [3:0] op, input logic [8:0] fc);
    tty_instr_t it;
    it = rand_instr(op);
    it.fc = fc;
    instr_queue.push_back(it);
  endfunction

  // Queues one random sequence: mostly complete transfers, some noise.
  function automatic void add_random_sequence();
    tty_instr_t it;
    case ($urandom_range(0, 9))
      0, 1: begin
        // Keyboard character: take it, let the char time end, test, read.
        it = rand_instr(ttio_pkg::OP_INA);
        it.cvalid = ($urandom_range(0, 7) != 0);
        it.fc = ina_code();
        instr_queue.push_back(it);
        add_rand(ttio_pkg::OP_INPUT_DONE, 9'($urandom));
        if ($urandom_range(0, 1))
          add_rand(ttio_pkg::OP_SKS, group_code(ttio_pkg::FG_0, ttio_pkg::FG_1,
                                                ttio_pkg::FG_4, ttio_pkg::FG_5));
        add_rand(ttio_pkg::OP_INA, ina_code());
      end
      2, 3: begin
        // Character output and its completion.
        add_rand(ttio_pkg::OP_OTA, group_code(ttio_pkg::FG_0, ttio_pkg::FG_2,
                                              ttio_pkg::FG_0, ttio_pkg::FG_2));
        if ($urandom_range(0, 1))
          add_rand(ttio_pkg::OP_SKS, group_code(ttio_pkg::FG_0, ttio_pkg::FG_1,
                                                ttio_pkg::FG_4, ttio_pkg::FG_5));
        add_rand(ttio_pkg::OP_OUTPUT_DONE, 9'($urandom));
      end
      4: begin
        // Dummy cycle, with or without an output waiting behind it.
        add_rand(ttio_pkg::OP_OCP, {ttio_pkg::FG_1, 6'($urandom)});
        if ($urandom_range(0, 3) != 0)
          add_rand(ttio_pkg::OP_OTA, group_code(ttio_pkg::FG_0, ttio_pkg::FG_2,
                                                ttio_pkg::FG_0, ttio_pkg::FG_2));
        add_rand(ttio_pkg::OP_DUMMY_DONE, 9'($urandom));
        add_rand(ttio_pkg::OP_OUTPUT_DONE, 9'($urandom));
      end
      5: begin
        it = rand_instr(ttio_pkg::OP_SMK);
        it.mword[ttio_pkg::MASK_BIT_POS] = ($urandom_range(0, 3) != 0);
        instr_queue.push_back(it);
      end
      6: add_rand(ttio_pkg::OP_SKS, group_code(ttio_pkg::FG_0, ttio_pkg::FG_1,
                                               ttio_pkg::FG_4, ttio_pkg::FG_5));
      7: add_rand(ttio_pkg::OP_OCP, group_code(ttio_pkg::FG_0, ttio_pkg::FG_1,
                                               ttio_pkg::FG_0, ttio_pkg::FG_1));
      8: instr_queue.push_back(rand_instr(4'($urandom_range(0, 15))));
      default: begin
        if ($urandom_range(0, 3) == 0)
          instr_queue.push_back(rand_instr(ttio_pkg::OP_CLEAR));
        else
          instr_queue.push_back(rand_instr(4'($urandom_range(0, 7))));
      end
    endcase
  endfunction

  // Reports one result field that differs from its prediction.
  function automatic void compare_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("mismatch at %0t on %s: expected %h, got %h", $realtime, fname, want, got);
    end
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    rst_n = 1'b0;
    clear_device();

    // Keyboard input with the mask set and a full read.
    add_instr(ttio_pkg::OP_SMK, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0020);
    add_instr(ttio_pkg::OP_INA, ttio_pkg::FC_INA_WORD, 16'h0000, 1'b1, 8'hFF, 16'h0000);
    add_instr(ttio_pkg::OP_INA, ttio_pkg::FC_INA_WORD, 16'h0000, 1'b1, 8'h55, 16'h0000);
    add_instr(ttio_pkg::OP_INPUT_DONE, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_SKS, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_SKS, 9'o400, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_INA, ttio_pkg::FC_INA_WORD, 16'h0000, 1'b0, 8'h00, 16'h0000);
    // An unknown read code is not checked while the device is not ready.
    add_instr(ttio_pkg::OP_INA, 9'o777, 16'hFFFF, 1'b0, 8'hFF, 16'hFFFF);
    // Stop character with the parity bit set, seen by the stop-code skip, then a six-bit read.
    add_instr(ttio_pkg::OP_INA, ttio_pkg::FC_INA_SIX, 16'h0000, 1'b1, 8'h93, 16'h0000);
    add_instr(ttio_pkg::OP_INPUT_DONE, 9'o777, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_SKS, 9'o500, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_INA, ttio_pkg::FC_INA_SIX, 16'h0000, 1'b0, 8'h00, 16'h0000);
    // An unknown read code while ready still clears ready and the interrupt.
    add_instr(ttio_pkg::OP_INA, ttio_pkg::FC_INA_WORD, 16'h0000, 1'b1, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_INPUT_DONE, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_INA, 9'o777, 16'h0000, 1'b0, 8'h00, 16'h0000);
    // Dummy cycle with an output waiting behind it, then a converted output.
    add_instr(ttio_pkg::OP_OCP, 9'o100, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_OTA, 9'o000, 16'hFFFF, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_DUMMY_DONE, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_OUTPUT_DONE, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_OTA, 9'o277, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_OUTPUT_DONE, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0000);
    // Unknown codes for output, control and skip, then a valid skip and control.
    add_instr(ttio_pkg::OP_OTA, 9'o300, 16'hFFDF, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_OCP, 9'o200, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_SKS, 9'o777, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_SKS, 9'o177, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(ttio_pkg::OP_OCP, 9'o077, 16'h0000, 1'b0, 8'h00, 16'h0000);
    // A completion event in the wrong activity, an unused operation, a mask clear and a clear.
    add_instr(ttio_pkg::OP_DUMMY_DONE, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_instr(4'd15, 9'o777, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF);
    add_instr(ttio_pkg::OP_SMK, 9'o000, 16'h0000, 1'b0, 8'h00, 16'hFFDF);
    add_instr(ttio_pkg::OP_CLEAR, 9'o000, 16'h0000, 1'b0, 8'h00, 16'h0000);

    while (instr_queue.size() < RANDOM_ITEMS + 30) add_random_sequence();
    instrs_total = instr_queue.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (!(instrs_accepted == instrs_total && pending_replies.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver: presents queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_replies.push_back(execute_instr(on_bus));
        instrs_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (instr_queue.size() > 0 && (calm_window || $urandom_range(0, 99) >= 33)) begin
          on_bus   <= instr_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and drives the receiver's ready.
  always @(posedge clk) begin
    tty_reply_t got;
    tty_reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_status_flag, out_data_out, out_irq_level, out_start_timer,
               out_print_valid, out_print_char, out_bad_function};
        if (pending_replies.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result at %0t: %h", $realtime, got);
        end else begin
          want = pending_replies.pop_front();
          compare_field("status_flag", 16'(want.status), 16'(got.status));
          compare_field("data_out", want.data, got.data);
          compare_field("irq_level", 16'(want.irq), 16'(got.irq));
          compare_field("start_timer", 16'(want.timer), 16'(got.timer));
          compare_field("print_valid", 16'(want.pvalid), 16'(got.pvalid));
          compare_field("print_char", 16'(want.pchar), 16'(got.pchar));
          compare_field("bad_function", 16'(want.bad), 16'(got.bad));
        end
      end

      // One long hold-off lets the block fill up and stall its input.
      if (!hold_done && instrs_accepted >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm_window) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

@@ teletype_io_interface.f @@
rtl/core/ttio_pkg.sv
rtl/core/teletype_io_interface.sv
rtl/core/ttio_checker.sv
tb/tb_teletype_io_interface.sv
